// ----- rtl/assert_macros.svh -----
// assertion macros shared by the steering core rtl
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define FLFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// condition must never be true out of reset
`define FLFS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define FLFS_ASSERT(lbl, prop, msg)
`define FLFS_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ----- rtl/flfs_pkg.sv -----
// types, constants and speed tables for the fuzzy line-follow steering core
// no dependencies
package flfs_pkg;

  // field widths
  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned THR_W        = 16;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CMD_W        = 3;
  localparam int unsigned FWD_W        = 7;
  localparam int unsigned TURN_W       = 10;
  localparam int unsigned CLASSES_W    = 8;
  localparam int unsigned PROD_W       = 2 * THR_W;
  localparam int unsigned NUM_SENSORS  = 4;

  // default for the used sample bits
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  // threshold register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLACK_FALL_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLACK_END        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WHITE_RISE_START = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WHITE_FULL       = 2'd3;

  // threshold reset values
  localparam logic [THR_W-1:0] RST_BLACK_FALL_START = 16'd9000;
  localparam logic [THR_W-1:0] RST_BLACK_END        = 16'd15000;
  localparam logic [THR_W-1:0] RST_WHITE_RISE_START = 16'd20000;
  localparam logic [THR_W-1:0] RST_WHITE_FULL       = 16'd25000;

  // sensor index order
  localparam int unsigned SNS_WHEEL_LEFT  = 0;
  localparam int unsigned SNS_FRONT_LEFT  = 1;
  localparam int unsigned SNS_FRONT_RIGHT = 2;
  localparam int unsigned SNS_WHEEL_RIGHT = 3;

  typedef enum logic [1:0] {
    CLS_BLACK = 2'd0,
    CLS_GREY  = 2'd1,
    CLS_WHITE = 2'd2
  } class_e;

  // which part of the membership curves a sample falls in
  typedef enum logic [1:0] {
    REG_FULL_BLACK = 2'd0,
    REG_FULL_WHITE = 2'd1,
    REG_LOW        = 2'd2,  // black against grey
    REG_HIGH       = 2'd3   // grey against white
  } region_e;

  typedef enum logic [CMD_W-1:0] {
    CMD_HALT       = 3'd0,
    CMD_FORWARD    = 3'd1,
    CMD_SOFT_RIGHT = 3'd2,
    CMD_HARD_RIGHT = 3'd3,
    CMD_SOFT_LEFT  = 3'd4,
    CMD_HARD_LEFT  = 3'd5,
    CMD_TURN_LEFT  = 3'd6,
    CMD_TURN_RIGHT = 3'd7
  } cmd_e;

  typedef struct packed {
    logic [THR_W-1:0] black_fall_start;
    logic [THR_W-1:0] black_end;
    logic [THR_W-1:0] white_rise_start;
    logic [THR_W-1:0] white_full;
  } thr_t;

  // load strobes for the two lane stages
  typedef struct packed {
    logic ld_ratio;
    logic ld_prod;
  } lane_ctl_t;

  typedef struct packed {
    cmd_e                     cmd;
    logic [FWD_W-1:0]         fwd;
    logic signed [TURN_W-1:0] turn;
    logic                     held;
    logic [CLASSES_W-1:0]     classes;
  } result_t;

  // translation speed in thousandths
  function automatic logic [FWD_W-1:0] cmd_speed(cmd_e cmd);
    logic [FWD_W-1:0] v;
    unique case (cmd)
      CMD_HALT:       v = 7'd0;
      CMD_FORWARD:    v = 7'd80;
      CMD_SOFT_RIGHT: v = 7'd60;
      CMD_HARD_RIGHT: v = 7'd30;
      CMD_SOFT_LEFT:  v = 7'd60;
      CMD_HARD_LEFT:  v = 7'd30;
      CMD_TURN_LEFT:  v = 7'd0;
      CMD_TURN_RIGHT: v = 7'd0;
    endcase
    return v;
  endfunction

  // rotation rate in thousandths, positive turns left
  function automatic logic signed [TURN_W-1:0] cmd_turn(cmd_e cmd);
    logic signed [TURN_W-1:0] v;
    unique case (cmd)
      CMD_HALT:       v = 10'sd0;
      CMD_FORWARD:    v = 10'sd0;
      CMD_SOFT_RIGHT: v = -10'sd300;
      CMD_HARD_RIGHT: v = -10'sd500;
      CMD_SOFT_LEFT:  v = 10'sd300;
      CMD_HARD_LEFT:  v = 10'sd500;
      CMD_TURN_LEFT:  v = 10'sd500;
      CMD_TURN_RIGHT: v = -10'sd500;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/flfs_intf.sv -----
// valid/ready channel interfaces for sample words and steering words
// depends on flfs_pkg
interface flfs_sample_if;
  logic                          valid;
  logic                          ready;
  logic [flfs_pkg::SAMPLE_W-1:0] wheel_left_sample;
  logic [flfs_pkg::SAMPLE_W-1:0] front_left_sample;
  logic [flfs_pkg::SAMPLE_W-1:0] front_right_sample;
  logic [flfs_pkg::SAMPLE_W-1:0] wheel_right_sample;

  modport source (
    output valid, wheel_left_sample, front_left_sample, front_right_sample,
           wheel_right_sample,
    input  ready
  );
  modport sink (
    input  valid, wheel_left_sample, front_left_sample, front_right_sample,
           wheel_right_sample,
    output ready
  );
endinterface

interface flfs_steer_if;
  logic                               valid;
  logic                               ready;
  logic [flfs_pkg::CMD_W-1:0]         steer_command;
  logic [flfs_pkg::FWD_W-1:0]         forward_speed;
  logic signed [flfs_pkg::TURN_W-1:0] turn_rate;
  logic                               command_held;
  logic [flfs_pkg::CLASSES_W-1:0]     sensor_classes;

  modport source (
    output valid, steer_command, forward_speed, turn_rate, command_held,
           sensor_classes,
    input  ready
  );
  modport sink (
    input  valid, steer_command, forward_speed, turn_rate, command_held,
           sensor_classes,
    output ready
  );
endinterface

// ----- rtl/fuzzy_line_follow_steering_core.sv -----
// top level of the fuzzy line-follow steering core
// depends on flfs_pkg, flfs_intf, flfs_lane, flfs_rules and assert_macros.svh
//
// Usage: each word on samples_i carries the four floor reflectance samples
// of one control tick (wheel left, front left, front right, wheel right).
// Every accepted word gives exactly one word on steer_o: steering command,
// forward speed and turn rate in thousandths, a held flag when no rule
// fired and the last command was repeated, and the four sensor classes.
// Thresholds are written through cfg_we_i / cfg_idx_i / cfg_wdata_i while
// no word is in flight; writes take effect at the next clock edge.
// Pipeline: a word passes through the input register, ratio stage,
// cross-product stage and result register before it is presented on steer_o.
// Throughput: one word per cycle while steer_o.ready is high; the per-lane 16x16
// cross products sit in their own stage so each stage holds one multiplier level.
// Reset: thresholds return to 9000/15000/20000/25000, the pipeline empties
// and the last command returns to halt.
// Stall: each stage has its own valid bit and ready, so when steer_o.ready
// is low words keep moving into empty stages; samples_i.ready drops only
// once all four stages are full.
`include "assert_macros.svh"

module fuzzy_line_follow_steering_core #(
  parameter int unsigned SAMPLE_BITS = flfs_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  flfs_sample_if.sink                     samples_i,
  flfs_steer_if.source                    steer_o,
  input  logic                            cfg_we_i,
  input  logic [flfs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [flfs_pkg::THR_W-1:0]      cfg_wdata_i
);

  flfs_pkg::thr_t      thr_q;
  logic                v1_q, v2_q, v3_q, vo_q;
  logic                rdy1, rdy2, rdy3, rdyo;
  logic                ld1, ld2, ld3, ldo;
  logic [SAMPLE_BITS-1:0] smp_q [flfs_pkg::NUM_SENSORS];
  flfs_pkg::lane_ctl_t lane_ctl;
  flfs_pkg::class_e    cls [flfs_pkg::NUM_SENSORS];
  flfs_pkg::result_t   res;

  // threshold registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q.black_fall_start <= flfs_pkg::RST_BLACK_FALL_START;
      thr_q.black_end        <= flfs_pkg::RST_BLACK_END;
      thr_q.white_rise_start <= flfs_pkg::RST_WHITE_RISE_START;
      thr_q.white_full       <= flfs_pkg::RST_WHITE_FULL;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        flfs_pkg::CFG_BLACK_FALL_START: thr_q.black_fall_start <= cfg_wdata_i;
        flfs_pkg::CFG_BLACK_END:        thr_q.black_end        <= cfg_wdata_i;
        flfs_pkg::CFG_WHITE_RISE_START: thr_q.white_rise_start <= cfg_wdata_i;
        flfs_pkg::CFG_WHITE_FULL:       thr_q.white_full       <= cfg_wdata_i;
      endcase
    end
  end

  // per-stage ready chain
  assign rdyo = !vo_q || steer_o.ready;
  assign rdy3 = !v3_q || rdyo;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign ld1 = samples_i.valid && rdy1;
  assign ld2 = v1_q && rdy2;
  assign ld3 = v2_q && rdy3;
  assign ldo = v3_q && rdyo;

  assign samples_i.ready = rdy1;

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= samples_i.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdyo) vo_q <= v3_q;
    end
  end

  // input register, only the used sample bits are kept
  always_ff @(posedge clk_i) begin
    if (ld1) begin
      smp_q[flfs_pkg::SNS_WHEEL_LEFT]  <= samples_i.wheel_left_sample[SAMPLE_BITS-1:0];
      smp_q[flfs_pkg::SNS_FRONT_LEFT]  <= samples_i.front_left_sample[SAMPLE_BITS-1:0];
      smp_q[flfs_pkg::SNS_FRONT_RIGHT] <= samples_i.front_right_sample[SAMPLE_BITS-1:0];
      smp_q[flfs_pkg::SNS_WHEEL_RIGHT] <= samples_i.wheel_right_sample[SAMPLE_BITS-1:0];
    end
  end

  assign lane_ctl.ld_ratio = ld2;
  assign lane_ctl.ld_prod  = ld3;

  // one classification lane per sensor
  for (genvar g = 0; g < flfs_pkg::NUM_SENSORS; g++) begin : g_lane
    flfs_lane #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane (
      .clk_i    (clk_i),
      .ctl_i    (lane_ctl),
      .thr_i    (thr_q),
      .sample_i (smp_q[g]),
      .cls_o    (cls[g])
    );
  end

  flfs_rules u_rules (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ld_i   (ldo),
    .cls_i  (cls),
    .res_o  (res)
  );

  // output word
  assign steer_o.valid          = vo_q;
  assign steer_o.steer_command  = res.cmd;
  assign steer_o.forward_speed  = res.fwd;
  assign steer_o.turn_rate      = res.turn;
  assign steer_o.command_held   = res.held;
  assign steer_o.sensor_classes = res.classes;

  // an empty input stage always takes a word
  `FLFS_ASSERT(a_empty_ready, !v1_q |-> samples_i.ready, "input stage empty but not ready")
  // a taken word with nothing behind it leaves the output empty
  `FLFS_ASSERT(a_out_drains, (steer_o.valid && steer_o.ready && !v3_q) |=> !steer_o.valid, "output word repeated")
  // no word taken while every stage is full and the output stalls
  `FLFS_ASSERT_NEVER(a_full_stall, v1_q && v2_q && v3_q && vo_q && !steer_o.ready && samples_i.ready, "accepted into a full pipeline")

endmodule

// ----- rtl/flfs_lane.sv -----
// one sensor lane: membership ratios, cross products and class decision
// depends on flfs_pkg
module flfs_lane #(
  parameter int unsigned SAMPLE_BITS = flfs_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  flfs_pkg::lane_ctl_t    ctl_i,
  input  flfs_pkg::thr_t         thr_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output flfs_pkg::class_e       cls_o
);

  localparam int unsigned W = flfs_pkg::THR_W;

  logic [W-1:0]       s;
  logic [W:0]         mid_sum;
  logic [W-1:0]       gm;
  flfs_pkg::region_e  region_d, region_q, region2_q;
  logic [W-1:0]       an_raw, ad_raw, bn_raw, bd_raw;
  logic [W-1:0]       an_d, ad_d, bn_d, bd_d;
  logic [W-1:0]       an_q, ad_q, bn_q, bd_q;
  logic [flfs_pkg::PROD_W-1:0] pa_q, pb_q;
  logic               bnz_q;
  logic               a_gt_b;

  // grey peak and region of the curves
  assign s       = W'(sample_i);
  assign mid_sum = {1'b0, thr_i.black_fall_start} + {1'b0, thr_i.white_full};
  assign gm      = mid_sum[W:1];

  always_comb begin
    an_raw   = '0;
    ad_raw   = '0;
    bn_raw   = '0;
    bd_raw   = '0;
    region_d = flfs_pkg::REG_HIGH;
    priority if (s < thr_i.black_fall_start) begin
      region_d = flfs_pkg::REG_FULL_BLACK;
    end else if (s > thr_i.white_full) begin
      region_d = flfs_pkg::REG_FULL_WHITE;
    end else if (s < gm) begin
      // a is black, b is grey
      region_d = flfs_pkg::REG_LOW;
      an_raw   = (s <= thr_i.black_end) ? thr_i.black_end - s : '0;
      ad_raw   = thr_i.black_end - thr_i.black_fall_start;
      bn_raw   = s - thr_i.black_fall_start;
      bd_raw   = gm - thr_i.black_fall_start;
    end else begin
      // a is grey, b is white
      region_d = flfs_pkg::REG_HIGH;
      an_raw   = (s < thr_i.white_full) ? thr_i.white_full - s : '0;
      ad_raw   = thr_i.white_full - gm;
      bn_raw   = (s >= thr_i.white_rise_start) ? s - thr_i.white_rise_start : '0;
      bd_raw   = thr_i.white_full - thr_i.white_rise_start;
    end
  end

  // a zero numerator or a zero-width ramp reads as 0/1
  always_comb begin
    if (an_raw == '0 || ad_raw == '0) begin
      an_d = '0;
      ad_d = W'(1);
    end else begin
      an_d = an_raw;
      ad_d = ad_raw;
    end
    if (bn_raw == '0 || bd_raw == '0) begin
      bn_d = '0;
      bd_d = W'(1);
    end else begin
      bn_d = bn_raw;
      bd_d = bd_raw;
    end
  end

  // ratio stage
  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_ratio) begin
      region_q <= region_d;
      an_q     <= an_d;
      ad_q     <= ad_d;
      bn_q     <= bn_d;
      bd_q     <= bd_d;
    end
  end

  // cross-product stage
  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_prod) begin
      region2_q <= region_q;
      pa_q      <= flfs_pkg::PROD_W'(an_q) * flfs_pkg::PROD_W'(bd_q);
      pb_q      <= flfs_pkg::PROD_W'(bn_q) * flfs_pkg::PROD_W'(ad_q);
      bnz_q     <= (bn_q != '0);
    end
  end

  // class pick, ties go to the b class: grey in the low region, white in the high region
  assign a_gt_b = (pa_q > pb_q);

  always_comb begin
    unique case (region2_q)
      flfs_pkg::REG_FULL_BLACK: cls_o = flfs_pkg::CLS_BLACK;
      flfs_pkg::REG_FULL_WHITE: cls_o = flfs_pkg::CLS_WHITE;
      flfs_pkg::REG_LOW: begin
        if (a_gt_b)     cls_o = flfs_pkg::CLS_BLACK;
        else if (bnz_q) cls_o = flfs_pkg::CLS_GREY;
        else            cls_o = flfs_pkg::CLS_WHITE;
      end
      flfs_pkg::REG_HIGH: cls_o = a_gt_b ? flfs_pkg::CLS_GREY : flfs_pkg::CLS_WHITE;
    endcase
  end

endmodule

// ----- rtl/flfs_rules.sv -----
// rule tree, held-command tracking and result register
// depends on flfs_pkg and assert_macros.svh
`include "assert_macros.svh"

module flfs_rules (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               ld_i,
  input  flfs_pkg::class_e   cls_i [flfs_pkg::NUM_SENSORS],
  output flfs_pkg::result_t  res_o
);

  flfs_pkg::class_e wl, fl, fr, wr;
  flfs_pkg::cmd_e   rule_cmd;
  logic             fired;
  flfs_pkg::cmd_e   cmd_d, cmd_q;
  logic             held_q;
  logic [flfs_pkg::FWD_W-1:0]         fwd_q;
  logic signed [flfs_pkg::TURN_W-1:0] turn_q;
  logic [flfs_pkg::CLASSES_W-1:0]     classes_q;
  logic             all_same;

  assign wl = cls_i[flfs_pkg::SNS_WHEEL_LEFT];
  assign fl = cls_i[flfs_pkg::SNS_FRONT_LEFT];
  assign fr = cls_i[flfs_pkg::SNS_FRONT_RIGHT];
  assign wr = cls_i[flfs_pkg::SNS_WHEEL_RIGHT];

  assign all_same = (wl == fl) && (fl == fr) && (fr == wr);

  // priority rule tree; fronts both grey with no grey wheel fires nothing
  always_comb begin
    rule_cmd = flfs_pkg::CMD_HALT;
    fired    = 1'b1;
    priority if (all_same) begin
      rule_cmd = flfs_pkg::CMD_HALT;
    end else if (fl == flfs_pkg::CLS_BLACK && fr == flfs_pkg::CLS_BLACK) begin
      rule_cmd = flfs_pkg::CMD_FORWARD;
    end else if (fl == flfs_pkg::CLS_BLACK || fr == flfs_pkg::CLS_BLACK) begin
      priority if (fl == flfs_pkg::CLS_GREY)       rule_cmd = flfs_pkg::CMD_SOFT_RIGHT;
      else if (fl == flfs_pkg::CLS_WHITE)          rule_cmd = flfs_pkg::CMD_HARD_RIGHT;
      else if (fr == flfs_pkg::CLS_GREY)           rule_cmd = flfs_pkg::CMD_SOFT_LEFT;
      else                                         rule_cmd = flfs_pkg::CMD_HARD_LEFT;
    end else if (wl == flfs_pkg::CLS_BLACK && wr == flfs_pkg::CLS_BLACK) begin
      rule_cmd = flfs_pkg::CMD_HALT;
    end else if (wl == flfs_pkg::CLS_BLACK) begin
      rule_cmd = flfs_pkg::CMD_TURN_LEFT;
    end else if (wr == flfs_pkg::CLS_BLACK) begin
      rule_cmd = flfs_pkg::CMD_TURN_RIGHT;
    end else if (fl == flfs_pkg::CLS_GREY && fr == flfs_pkg::CLS_GREY) begin
      priority if (wl == flfs_pkg::CLS_GREY)       rule_cmd = flfs_pkg::CMD_TURN_LEFT;
      else if (wr == flfs_pkg::CLS_GREY)           rule_cmd = flfs_pkg::CMD_TURN_RIGHT;
      else                                         fired    = 1'b0;
    end else if (fl == flfs_pkg::CLS_GREY) begin
      rule_cmd = flfs_pkg::CMD_TURN_LEFT;
    end else if (fr == flfs_pkg::CLS_GREY) begin
      rule_cmd = flfs_pkg::CMD_TURN_RIGHT;
    end else if (wl == flfs_pkg::CLS_GREY && wr == flfs_pkg::CLS_GREY) begin
      rule_cmd = flfs_pkg::CMD_HALT;
    end else if (wl == flfs_pkg::CLS_GREY) begin
      rule_cmd = flfs_pkg::CMD_TURN_LEFT;
    end else if (wr == flfs_pkg::CLS_GREY) begin
      rule_cmd = flfs_pkg::CMD_TURN_RIGHT;
    end else begin
      rule_cmd = flfs_pkg::CMD_HALT;
    end
  end

  // command register doubles as the last command
  assign cmd_d = fired ? rule_cmd : cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q <= flfs_pkg::CMD_HALT;
    end else if (ld_i) begin
      cmd_q <= cmd_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      fwd_q     <= flfs_pkg::cmd_speed(cmd_d);
      turn_q    <= flfs_pkg::cmd_turn(cmd_d);
      held_q    <= ~fired;
      classes_q <= {wr, fr, fl, wl};
    end
  end

  assign res_o.cmd     = cmd_q;
  assign res_o.fwd     = fwd_q;
  assign res_o.turn    = turn_q;
  assign res_o.held    = held_q;
  assign res_o.classes = classes_q;

  // a held word repeats the previous command
  `FLFS_ASSERT(a_held_repeats, (ld_i && !fired) |=> (held_q && cmd_q == $past(cmd_q)), "held word changed command")
  // an all-equal pattern always halts
  `FLFS_ASSERT(a_uniform_halts, (ld_i && all_same) |=> (cmd_q == flfs_pkg::CMD_HALT && !held_q), "uniform classes did not halt")
  // held only with both fronts grey and no grey wheel
  `FLFS_ASSERT(a_held_pattern, ($past(ld_i) && held_q) |-> (classes_q[3:2] == flfs_pkg::CLS_GREY && classes_q[5:4] == flfs_pkg::CLS_GREY && classes_q[1:0] != flfs_pkg::CLS_GREY && classes_q[7:6] != flfs_pkg::CLS_GREY), "held with a firing pattern")

endmodule
